// File: src/sap_pkg.sv
package sap_pkg;

  localparam int DIM_W = 13;
  localparam int CNT_W = 11;
  localparam int POS_W = DIM_W + 1;
  localparam int SUM_W = DIM_W + 2;

  localparam int MAX_ATLAS_DIM   = 4096;
  localparam int MAX_QUERY_COUNT = 1024;

  localparam logic [DIM_W-1:0] MAX_DIM  = DIM_W'(MAX_ATLAS_DIM);
  localparam logic [CNT_W-1:0] MAX_QCNT = CNT_W'(MAX_QUERY_COUNT);

  localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(1024);

  localparam logic REQ_PACK  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 1'b1;

  typedef struct packed {
    logic load;
    logic wrap;
    logic adv;
    logic clr_on_wrap;
  } sap_walk_ctl_t;

  typedef struct packed {
    logic             fits;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIM_W-1:0] step;
    logic [SUM_W-1:0] end_x;
    logic [SUM_W-1:0] end_y;
    logic [DIM_W-1:0] max_step;
  } sap_walk_st_t;

endpackage

// File: src/sap_if.sv
interface sap_in_if import sap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;
  logic [CNT_W-1:0] rect_count;

  modport source (output valid, req_type, rect_width, rect_height, rect_count,
                  input ready);
  modport sink   (input valid, req_type, rect_width, rect_height, rect_count,
                  output ready);
endinterface

interface sap_out_if import sap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [DIM_W-1:0] min_x;
  logic [DIM_W-1:0] min_y;
  logic [DIM_W-1:0] max_x;
  logic [DIM_W-1:0] max_y;
  logic             is_full;

  modport source (output valid, ok, min_x, min_y, max_x, max_y, is_full,
                  input ready);
  modport sink   (input valid, ok, min_x, min_y, max_x, max_y, is_full,
                  output ready);
endinterface

// File: src/shelf_atlas_packer.sv
// Shelf allocator for a 2-D atlas. Rectangles go left to right along the
// current row; one that does not fit the row first moves the cursor to a new
// row, and that move sticks even if the rectangle then does not fit in
// height, which sets is_full. Queries (req_type 1) walk rect_count copies of
// the same rectangle through a scratch copy of the cursor and leave the real
// state untouched. Each walker step is a row wrap state followed by a fit
// check and advance state. A pack passes through both states once before its
// result is registered; a query repeats them once per saturated copy and stops
// early when it runs out of room; oversized requests or a zero count answer
// straight from idle. A new beat is taken only once the previous result has
// been taken or is being taken. Atlas size registers are to be written by the
// user through the cfg port only while the block is idle; the block does not enforce it.
module shelf_atlas_packer import sap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_wdata,
  sap_in_if.sink               in_if,
  sap_out_if.source            out_if
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WRAP = 3'b010,
    ST_FIT  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] atlas_w_r, atlas_h_r, aw_eff, ah_eff;
  logic [DIM_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, row_r, row_nxt;
  logic             full_r, full_nxt;
  logic [DIM_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic             type_r, type_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sat;
  logic             in_beat, oversize;

  sap_walk_ctl_t    ctl;
  sap_walk_st_t     st;

  logic             res_load, res_ok;
  logic [DIM_W-1:0] res_x0, res_y0, res_x1, res_y1;
  logic             out_valid_r, out_ok_r, out_full_r;
  logic [DIM_W-1:0] out_x0_r, out_y0_r, out_x1_r, out_y1_r;

  assign aw_eff   = (atlas_w_r > MAX_DIM) ? MAX_DIM : atlas_w_r;
  assign ah_eff   = (atlas_h_r > MAX_DIM) ? MAX_DIM : atlas_h_r;
  assign cnt_sat  = (in_if.rect_count > MAX_QCNT) ? MAX_QCNT : in_if.rect_count;
  assign oversize = (in_if.rect_width >= aw_eff) || (in_if.rect_height >= ah_eff);

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_beat     = in_if.valid && in_if.ready;

  sap_walker u_walker (
    .clk       (clk),
    .ctl       (ctl),
    .init_x    (cur_x_r),
    .init_y    (cur_y_r),
    .init_step (row_r),
    .rect_w    (w_r),
    .rect_h    (h_r),
    .atlas_w   (aw_eff),
    .atlas_h   (ah_eff),
    .st        (st)
  );

  always_comb begin
    state_nxt = state_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    row_nxt   = row_r;
    full_nxt  = full_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    type_nxt  = type_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    res_load  = 1'b0;
    res_ok    = 1'b0;
    res_x0    = '0;
    res_y0    = '0;
    res_x1    = '0;
    res_y1    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          w_nxt    = in_if.rect_width;
          h_nxt    = in_if.rect_height;
          type_nxt = in_if.req_type;
          cnt_nxt  = cnt_sat;
          if (oversize) begin
            res_load = 1'b1;
          end else if (in_if.req_type == REQ_QUERY && cnt_sat == '0) begin
            res_load = 1'b1;
            res_ok   = 1'b1;
          end else begin
            ctl.load  = 1'b1;
            state_nxt = ST_WRAP;
          end
        end
      end
      ST_WRAP: begin
        ctl.wrap        = 1'b1;
        ctl.clr_on_wrap = (type_r == REQ_PACK);
        state_nxt       = ST_FIT;
      end
      ST_FIT: begin
        if (type_r == REQ_PACK) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (st.fits) begin
            res_ok    = 1'b1;
            res_x0    = st.x[DIM_W-1:0];
            res_y0    = st.y[DIM_W-1:0];
            res_x1    = st.end_x[DIM_W-1:0];
            res_y1    = st.end_y[DIM_W-1:0];
            cur_x_nxt = st.end_x[DIM_W-1:0];
            cur_y_nxt = st.y[DIM_W-1:0];
            row_nxt   = st.max_step;
          end else begin
            // the row wrap stays even though the rectangle is refused
            full_nxt  = 1'b1;
            cur_x_nxt = st.x[DIM_W-1:0];
            cur_y_nxt = st.y[DIM_W-1:0];
            row_nxt   = st.step;
          end
        end else if (!st.fits) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cnt_r == CNT_W'(1)) begin
          res_load  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.adv   = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_WRAP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      atlas_w_r   <= ATLAS_RESET;
      atlas_h_r   <= ATLAS_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      row_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      row_r   <= row_nxt;
      full_r  <= full_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ATLAS_W: atlas_w_r <= cfg_wdata;
          CFG_ATLAS_H: atlas_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (res_load)
        out_valid_r <= 1'b1;
      else if (out_if.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    type_r <= type_nxt;
    cnt_r  <= cnt_nxt;
    if (res_load) begin
      out_ok_r   <= res_ok;
      out_x0_r   <= res_x0;
      out_y0_r   <= res_y0;
      out_x1_r   <= res_x1;
      out_y1_r   <= res_y1;
      out_full_r <= full_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.ok      = out_ok_r;
  assign out_if.min_x   = out_x0_r;
  assign out_if.min_y   = out_y0_r;
  assign out_if.max_x   = out_x1_r;
  assign out_if.max_y   = out_y1_r;
  assign out_if.is_full = out_full_r;

`ifndef SYNTHESIS
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(full_r))
    else $error("full flag cleared without reset");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_x_r <= MAX_DIM)
    else $error("cursor x beyond atlas limit");

  a_rect_in_atlas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r |->
      out_x1_r <= aw_eff && out_y1_r <= ah_eff &&
      out_x0_r <= out_x1_r && out_y0_r <= out_y1_r)
    else $error("placed rectangle outside the atlas");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRAP || state_r == ST_FIT) |-> !in_if.ready)
    else $error("input taken while a request is in flight");
`endif

endmodule

// File: src/sap_walker.sv
module sap_walker import sap_pkg::*; (
  input  logic             clk,
  input  sap_walk_ctl_t    ctl,
  input  logic [DIM_W-1:0] init_x,
  input  logic [DIM_W-1:0] init_y,
  input  logic [DIM_W-1:0] init_step,
  input  logic [DIM_W-1:0] rect_w,
  input  logic [DIM_W-1:0] rect_h,
  input  logic [DIM_W-1:0] atlas_w,
  input  logic [DIM_W-1:0] atlas_h,
  output sap_walk_st_t     st
);

  logic [POS_W-1:0] x_r, y_r;
  logic [DIM_W-1:0] step_r;
  logic [SUM_W-1:0] sum_x, sum_ystep, sum_yh;
  logic             need_wrap;
  logic [DIM_W-1:0] max_step;

  always_comb begin
    sum_x     = SUM_W'(x_r) + SUM_W'(rect_w);
    sum_ystep = SUM_W'(y_r) + SUM_W'(step_r);
    sum_yh    = SUM_W'(y_r) + SUM_W'(rect_h);
    need_wrap = sum_x > SUM_W'(atlas_w);
    max_step  = (rect_h > step_r) ? rect_h : step_r;

    st.fits     = sum_yh <= SUM_W'(atlas_h);
    st.x        = x_r;
    st.y        = y_r;
    st.step     = step_r;
    st.end_x    = sum_x;
    st.end_y    = sum_yh;
    st.max_step = max_step;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r    <= POS_W'(init_x);
      y_r    <= POS_W'(init_y);
      step_r <= init_step;
    end else if (ctl.wrap) begin
      if (need_wrap) begin
        x_r <= '0;
        y_r <= sum_ystep[POS_W-1:0];
        if (ctl.clr_on_wrap) step_r <= '0;
      end
    end else if (ctl.adv) begin
      x_r    <= sum_x[POS_W-1:0];
      step_r <= max_step;
    end
  end

endmodule

// File: sim/tb_shelf_atlas_packer.sv
module tb_shelf_atlas_packer;
  import sap_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int HOLD_AT    = 500;   // request count at which the long output stall starts
  localparam int HOLD_LEN   = 400;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic             req_type;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [CNT_W-1:0] rect_count;
  } shelf_req_t;

  typedef struct {
    logic             ok;
    logic [DIM_W-1:0] min_x;
    logic [DIM_W-1:0] min_y;
    logic [DIM_W-1:0] max_x;
    logic [DIM_W-1:0] max_y;
    logic             is_full;
  } shelf_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_wdata;

  sap_in_if  in_if ();
  sap_out_if out_if ();

  shelf_atlas_packer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // shadow of the allocator
  logic [DIM_W-1:0] atlas_w;
  logic [DIM_W-1:0] atlas_h;
  logic [POS_W-1:0] cur_x     = '0;
  logic [POS_W-1:0] cur_y     = '0;
  logic [DIM_W-1:0] row_h     = '0;
  logic             full_seen = 1'b0;

  shelf_req_t req_backlog[$];
  shelf_res_t placements_due[$];
  shelf_req_t on_offer;

  int burst_left    = 1;
  int gap_left      = 0;
  int hold_left     = 0;
  bit hold_fired    = 1'b0;
  int ready_mode    = 0;
  int mode_left     = 0;
  int reqs_taken    = 0;
  int queries_taken = 0;
  int results_seen  = 0;
  int granted       = 0;
  int error_count   = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic shelf_res_t shelf_place(input shelf_req_t r);
    shelf_res_t  res;
    int unsigned aw, ah, n, x, y, step, i;
    res = '{default: '0};
    aw = (int'(atlas_w) > MAX_ATLAS_DIM) ? MAX_ATLAS_DIM : atlas_w;
    ah = (int'(atlas_h) > MAX_ATLAS_DIM) ? MAX_ATLAS_DIM : atlas_h;
    x = cur_x;
    y = cur_y;
    step = row_h;
    if (r.rect_width < aw && r.rect_height < ah) begin
      if (r.req_type == REQ_QUERY) begin
        n = (r.rect_count > MAX_QUERY_COUNT) ? MAX_QUERY_COUNT : r.rect_count;
        res.ok = 1'b1;
        // scratch walk; the row height carries across wraps here
        for (i = 0; i < n; i++) begin
          if (x + r.rect_width > aw) begin
            x = 0;
            y += step;
          end
          if (y + r.rect_height > ah) begin
            res.ok = 1'b0;
            break;
          end
          x += r.rect_width;
          if (r.rect_height > step) step = r.rect_height;
        end
      end else begin
        // the wrap sticks even when the rectangle then fails
        if (x + r.rect_width > aw) begin
          x = 0;
          y += step;
          step = 0;
        end
        if (y + r.rect_height > ah) begin
          full_seen = 1'b1;
        end else begin
          res.ok    = 1'b1;
          res.min_x = DIM_W'(x);
          res.min_y = DIM_W'(y);
          res.max_x = DIM_W'(x + r.rect_width);
          res.max_y = DIM_W'(y + r.rect_height);
          x += r.rect_width;
          if (r.rect_height > step) step = r.rect_height;
        end
        cur_x = POS_W'(x);
        cur_y = POS_W'(y);
        row_h = DIM_W'(step);
      end
    end
    res.is_full = full_seen;
    return res;
  endfunction

  function automatic int near_limit(input int unsigned d);
    case ($urandom_range(0, 3))
      0:       return int'(d) - 1;
      1:       return d;
      2:       return d + 1;
      default: return 0;
    endcase
  endfunction

  function automatic shelf_req_t rand_req(input int unsigned aw, input int unsigned ah);
    shelf_req_t  r;
    int unsigned pick, wmax, hmax;
    pick = $urandom_range(0, 99);
    wmax = (aw > 6) ? aw / 6 : aw;
    hmax = (ah > 200) ? 20 : ((ah > 5) ? ah / 5 : ah);
    r.req_type    = ($urandom_range(0, 99) < 35) ? REQ_QUERY : REQ_PACK;
    r.rect_width  = DIM_W'($urandom_range(0, wmax));
    r.rect_height = DIM_W'($urandom_range(0, hmax));
    r.rect_count  = CNT_W'($urandom_range(0, 6));
    if (r.req_type == REQ_PACK) begin
      r.rect_count = CNT_W'($urandom_range(0, 2047));
    end else if ($urandom_range(0, 4) == 0) begin
      r.rect_count = CNT_W'($urandom_range(7, 60));
    end
    if (pick < 6) begin
      r.rect_width  = DIM_W'($urandom_range(0, 8191));
      r.rect_height = DIM_W'($urandom_range(0, 8191));
      r.rect_count  = CNT_W'($urandom_range(0, 2047));
    end else if (pick < 11) begin
      r.rect_width = DIM_W'(near_limit(aw));
    end else if (pick < 16) begin
      r.rect_height = DIM_W'(near_limit(ah));
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (error_count < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [DIM_W-1:0] got,
                             input logic [DIM_W-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    end
  endtask

  task automatic add_req(input logic t, input int w, input int h, input int n);
    shelf_req_t r;
    r.req_type    = t;
    r.rect_width  = DIM_W'(w);
    r.rect_height = DIM_W'(h);
    r.rect_count  = CNT_W'(n);
    req_backlog = {req_backlog, r};
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_if.valid || placements_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_atlas(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ATLAS_W;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_ATLAS_H;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    atlas_w = w;
    atlas_h = h;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input int n);
    int unsigned aw, ah;
    int          k;
    write_atlas(w, h);
    aw = (int'(w) > MAX_ATLAS_DIM) ? MAX_ATLAS_DIM : w;
    ah = (int'(h) > MAX_ATLAS_DIM) ? MAX_ATLAS_DIM : h;
    for (k = 0; k < n; k++) req_backlog = {req_backlog, rand_req(aw, ah)};
    drain();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        placements_due = {placements_due, shelf_place(on_offer)};
        reqs_taken <= reqs_taken + 1;
        if (on_offer.req_type == REQ_QUERY) queries_taken <= queries_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          on_offer = req_backlog.pop_front();
          in_if.valid       <= 1'b1;
          in_if.req_type    <= on_offer.req_type;
          in_if.rect_width  <= on_offer.rect_width;
          in_if.rect_height <= on_offer.rect_height;
          in_if.rect_count  <= on_offer.rect_count;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold, so the block backs up while requests keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && reqs_taken >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_fired <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output stall pattern: always ready, mostly ready or mostly stalled
  always @(posedge clk) begin : rx_stall
    bit take;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_mode   <= 0;
      mode_left    <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 3) != 0);
        default: take = ($urandom_range(0, 3) == 0);
      endcase
      out_if.ready <= (hold_left == 0) && take;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    shelf_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (placements_due.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with nothing outstanding", results_seen));
      end else begin
        want = placements_due.pop_front();
        check_field("ok", DIM_W'(out_if.ok), DIM_W'(want.ok));
        check_field("min_x", out_if.min_x, want.min_x);
        check_field("min_y", out_if.min_y, want.min_y);
        check_field("max_x", out_if.max_x, want.max_x);
        check_field("max_y", out_if.max_y, want.max_y);
        check_field("is_full", DIM_W'(out_if.is_full), DIM_W'(want.is_full));
        if (want.ok) granted <= granted + 1;
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_ATLAS_W;
    cfg_wdata          = '0;
    atlas_w            = ATLAS_RESET;
    atlas_h            = ATLAS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset size of 1024 x 1024
    add_req(REQ_PACK, 0, 0, 0);             // zero-size rectangle
    add_req(REQ_PACK, 1, 1, 2047);
    add_req(REQ_QUERY, 0, 0, 0);            // count zero
    add_req(REQ_QUERY, 1, 1, 2047);         // count saturates
    add_req(REQ_QUERY, 1023, 1023, 1024);
    add_req(REQ_QUERY, 1023, 1023, 1);
    add_req(REQ_QUERY, 1024, 5, 0);         // oversized beats count zero
    add_req(REQ_QUERY, 5, 8191, 3);
    add_req(REQ_PACK, 1024, 1, 0);          // oversized width
    add_req(REQ_PACK, 1, 1024, 0);          // oversized height
    add_req(REQ_PACK, 8191, 8191, 0);
    add_req(REQ_PACK, 4096, 4096, 0);
    add_req(REQ_QUERY, 600, 1, 3);
    add_req(REQ_PACK, 1023, 5, 0);          // lands on the right edge
    add_req(REQ_QUERY, 2, 2, 7);
    add_req(REQ_PACK, 1, 1, 0);             // wraps to a new row
    add_req(REQ_PACK, 1023, 1, 0);
    add_req(REQ_PACK, 10, 1023, 0);         // wraps, then fails: full
    add_req(REQ_PACK, 3, 4, 0);             // full does not block
    add_req(REQ_QUERY, 1023, 1018, 1);
    drain();

    run_phase(13'd40, 13'd60, 80);
    run_phase(13'd0, 13'd0, 30);            // zero size: everything refused
    run_phase(13'd300, 13'd400, 160);
    run_phase(13'd8191, 13'd8191, 330);     // clamps to the max size
    run_phase(13'd2047, 13'd4096, 170);
    run_phase(13'd4096, 13'd4096, 160);
    repeat (20) @(negedge clk);
    if (placements_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", placements_due.size()));
    end

    $display("packed/queried %0d requests (%0d queries) over 7 atlas sizes", reqs_taken,
             queries_taken);
    $display("%0d results checked, %0d granted, %0d mismatches", results_seen, granted,
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 8000000);
    $display("timeout: %0d requests taken, %0d results seen", reqs_taken, results_seen);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
src/sap_pkg.sv
src/sap_if.sv
src/sap_walker.sv
src/shelf_atlas_packer.sv
sim/tb_shelf_atlas_packer.sv
